// ===== rtl/mtac_pkg.sv =====
// Package for the Mach table aerodynamic coefficient block.
// Types, constants and shared helpers; no dependencies.
package mtac_pkg;
  localparam int NTABLES = 5;
  localparam int ENTRIES_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LEN = 3'd0;
  localparam logic [2:0] TSEL_DAMP = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MACH     = 2'd1,
    ST_SPEED    = 2'd2,
    ST_BAD_LOAD = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_TSTART, S_RD_LAST, S_WT_LAST, S_CHK_LAST,
    S_SCAN_RD, S_SCAN_WT, S_SCAN_CHK, S_PREV_RD, S_PREV_WT, S_PREV_CHK,
    S_DIV, S_DIV_WAIT, S_INTERP, S_NEXT_T,
    S_M1, S_M2, S_M3, S_DMP_DIV, S_DMP_WAIT, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] drag_base;
    logic [23:0] drag_induced;
    logic [23:0] drag_total;
    logic [23:0] lift_total;
    logic [23:0] moment_static;
    logic [23:0] moment_damping;
    logic [23:0] moment_total;
    logic [23:0] lift_slope;
    logic [23:0] moment_slope;
    logic [23:0] damping_slope;
  } result_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  table_sel;
    logic [4:0]  entry_index;
    logic [15:0] entry_mach;
    logic [23:0] entry_value;
    logic [15:0] query_mach;
    logic [19:0] alpha;
    logic [22:0] pitch_rate;
    logic [15:0] speed;
  } item_t;

  // Saturate a wide signed value to Q8.16
  function automatic logic [23:0] sat24(input logic signed [63:0] v);
    logic [23:0] r;
    if (v > 64'sd8388607) r = 24'h7FFFFF;
    else if (v < -64'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

  // Round to nearest, ties away from zero, dropping SH fractional bits
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input logic [5:0] sh);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] q;
    mag  = v[63] ? (64'd0 - v) : v;
    half = 64'd1 << (sh - 6'd1);
    q    = (mag + half) >> sh;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction
endpackage

// ===== rtl/mtac_if.sv =====
// Valid/ready channel carrying one payload of type T.
// Depends on nothing.
interface mtac_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mtac_div.sv =====
// Shared restoring divider, one quotient bit a cycle, rounded to nearest.
// Depends on mtac_pkg.
module mtac_div import mtac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [47:0]        den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] mag, q, rem;
  logic [47:0] d;
  logic        neg, busy;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem, mag[63]} - {17'd0, d};

  // Restoring division, magnitude form
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= num[63];
        mag  <= num[63] ? 64'd0 - num : num;
        d    <= den;
        rem  <= 64'd0;
        q    <= 64'd0;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (cnt == 7'd0) begin
          // round: remainder*2 >= den
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -$signed(q + {63'd0, ({rem, 1'b0} >= {17'd0, d})})
                      : $signed(q + {63'd0, ({rem, 1'b0} >= {17'd0, d})});
        end else begin
          mag <= {mag[62:0], 1'b0};
          if (!trial[64]) begin
            rem <= trial[63:0];
            q   <= {q[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], mag[63]};
            q   <= {q[62:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
        end
      end
    end
  end
endmodule

// ===== rtl/mach_table_aero_coefficients.sv =====
// Mach-indexed aerodynamic coefficient block: five breakpoint tables in one
// synchronous memory, a sequencer that scans and interpolates, and a shared divider.
// Depends on mtac_pkg, mtac_if and mtac_div.
//
// A load transaction, or an evaluation at zero speed, passes through one working
// state before S_OUT. An evaluate transaction walks the five tables in turn through
// the single memory read port, stopping early at the first table whose range does
// not hold the query Mach: it reads and checks the last entry, scans entries upward
// and reads the lower neighbour when it must interpolate, then runs one division per
// interpolated table and, if every table held the query, one for pitch damping. The
// memory read port and the bit-serial divider set the rate. The result sits in an
// output register until taken, so the next transaction may start meanwhile. The
// tables are not cleared after reset.
module mach_table_aero_coefficients import mtac_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mtac_if.sink                  in_ch,
  mtac_if.source                out_ch
);
  localparam int DEPTH = NTABLES * ENTRIES;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  // Configuration registers
  logic [15:0] ref_len;
  logic [5:0]  tab_len [NTABLES];
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len <= 16'd256;
      for (int t = 0; t < NTABLES; t++) tab_len[t] <= 6'd1;
    end else if (cfg_we) begin
      if (cfg_idx == REG_REF_LEN) ref_len <= cfg_data;
      else if (32'(cfg_idx) <= NTABLES) tab_len[32'(cfg_idx) - 1] <= cfg_data[5:0];
    end
  end

  // Breakpoint memory: Mach in the top 16 bits, value below
  logic [39:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [39:0]   mem_wd, mem_rd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  state_t st, st_next;
  item_t  it;
  logic [2:0]     tsel;
  logic [IW-1:0]  idx;
  logic [LW-1:0]  nuse;
  logic [15:0]    m1;
  logic signed [23:0] v1, v0;
  logic [15:0]    m0;
  logic signed [23:0] coef [NTABLES];
  logic           bad_mach;
  result_t        res;
  result_t        out_data;
  logic           out_valid;
  logic signed [63:0] prod;
  logic           div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [47:0]    div_den;

  mtac_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Entries in use for the current table, clamped
  always_comb begin
    if (tab_len[tsel] == 6'd0) nuse = LW'(1);
    else if (32'(tab_len[tsel]) > ENTRIES) nuse = LW'(ENTRIES);
    else nuse = LW'(tab_len[tsel]);
  end

  logic [AW-1:0] tbase;
  assign tbase = AW'(32'(tsel) * ENTRIES);
  logic [15:0] q;
  assign q = it.query_mach;
  logic [15:0] rd_m;
  logic signed [23:0] rd_v;
  assign rd_m = mem_rd[39:24];
  assign rd_v = mem_rd[23:0];

  assign in_ch.ready  = (st == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Next-state logic
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:     if (in_ch.valid) st_next = in_ch.data.cmd ? S_TSTART : S_LOAD;
      S_LOAD:     st_next = S_OUT;
      S_TSTART:   st_next = (it.speed == 16'd0) ? S_OUT : S_RD_LAST;
      S_RD_LAST:  st_next = S_WT_LAST;
      S_WT_LAST:  st_next = S_CHK_LAST;
      S_CHK_LAST: st_next = S_SCAN_RD;
      S_SCAN_RD:  st_next = S_SCAN_WT;
      S_SCAN_WT:  st_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (bad_mach) st_next = S_NEXT_T;
        else if (rd_m >= q || LW'(idx) + LW'(1) >= nuse) begin
          if (idx == '0 || rd_m == q) st_next = S_NEXT_T;
          else st_next = S_PREV_RD;
        end else st_next = S_SCAN_RD;
      end
      S_PREV_RD:  st_next = S_PREV_WT;
      S_PREV_WT:  st_next = S_PREV_CHK;
      S_PREV_CHK: st_next = (m1 > rd_m) ? S_DIV : S_NEXT_T;
      S_DIV:      st_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) st_next = S_INTERP;
      S_INTERP:   st_next = S_NEXT_T;
      S_NEXT_T:   st_next = (bad_mach || tsel == TSEL_DAMP) ? S_M1 : S_RD_LAST;
      S_M1:       st_next = bad_mach ? S_OUT : S_M2;
      S_M2:       st_next = S_M3;
      S_M3:       st_next = S_DMP_DIV;
      S_DMP_DIV:  st_next = S_DMP_WAIT;
      S_DMP_WAIT: if (div_done) st_next = S_FIN;
      S_FIN:      st_next = S_OUT;
      S_OUT:      if (!out_valid || out_ch.ready) st_next = S_IDLE;
      default:    st_next = S_IDLE;
    endcase
  end

  // Memory and divider controls; the read address is held while data comes back
  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(32'(it.table_sel) * ENTRIES + 32'(it.entry_index));
    mem_wd = {it.entry_mach, it.entry_value};
    mem_ra = tbase + AW'(idx);
    div_start = 1'b0;
    div_num = 64'sd0;
    div_den = 48'd1;
    unique case (st)
      S_LOAD: mem_we = (it.table_sel <= TSEL_DAMP) && (32'(it.entry_index) < ENTRIES);
      S_RD_LAST, S_WT_LAST: mem_ra = tbase + AW'(nuse - LW'(1));
      S_PREV_RD, S_PREV_WT: mem_ra = tbase + AW'(idx) - AW'(1);
      S_DIV: begin
        div_start = 1'b1;
        div_num = prod;
        div_den = {32'd0, m1 - m0};
      end
      S_DMP_DIV: begin
        div_start = 1'b1;
        div_num = prod;
        div_den = {it.speed, 32'd0} >> 12;
      end
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == S_OUT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (in_ch.valid) begin
          it <= in_ch.data;
          res <= '0;
          tsel <= 3'd0;
          bad_mach <= 1'b0;
        end
        S_LOAD: if (!((it.table_sel <= TSEL_DAMP) && (32'(it.entry_index) < ENTRIES)))
          res.status <= ST_BAD_LOAD;
        S_TSTART: begin
          idx <= '0;
          if (it.speed == 16'd0) res.status <= ST_SPEED;
        end
        S_CHK_LAST: if (q > rd_m) bad_mach <= 1'b1;
        S_SCAN_CHK: begin
          m1 <= rd_m;
          v1 <= rd_v;
          coef[tsel] <= rd_v;
          if (idx == '0 && q < rd_m) bad_mach <= 1'b1;
          if (!(rd_m >= q || LW'(idx) + LW'(1) >= nuse)) idx <= idx + IW'(1);
        end
        S_PREV_CHK: begin
          m0 <= rd_m;
          v0 <= rd_v;
          prod <= 64'(signed'({1'b0, q - rd_m})) * (64'(v1) - 64'(rd_v));
        end
        S_INTERP: coef[tsel] <= sat24(64'(v0) + div_quo);
        S_NEXT_T: begin
          tsel <= tsel + 3'd1;
          idx <= '0;
        end
        S_M1: begin
          // value fields are still zero here, so an off-table query needs only its status
          if (bad_mach) res.status <= ST_MACH;
          prod <= 64'(signed'(it.alpha)) * 64'(signed'(it.alpha));
        end
        S_M2: begin
          res.drag_induced <= sat24(rnd_shift(64'(coef[1]) * prod, 6'd32));
          res.lift_total <= sat24(rnd_shift(64'(coef[2]) * 64'(signed'(it.alpha)), 6'd16));
          res.moment_static <= sat24(rnd_shift(64'(coef[3]) * 64'(signed'(it.alpha)), 6'd16));
          prod <= 64'(coef[4]) * 64'(signed'(it.pitch_rate));
        end
        S_M3: prod <= prod * 64'({1'b0, ref_len});
        S_FIN: begin
          res.drag_base <= coef[0];
          res.drag_total <= sat24(64'(coef[0]) + 64'(signed'(res.drag_induced)));
          res.moment_damping <= sat24(div_quo);
          res.moment_total <= sat24(64'(signed'(res.moment_static)) +
                                    64'(signed'(sat24(div_quo))));
          res.lift_slope <= coef[2];
          res.moment_slope <= coef[3];
          res.damping_slope <= coef[4];
        end
        S_OUT: if (!out_valid || out_ch.ready) out_data <= res;
        default: ;
      endcase
    end
  end
endmodule
